### design/clcd_pkg.sv
// Shared types and constants for the character LCD refresh controller.
package clcd_pkg;

  // Default geometry, handed to the top level parameters
  localparam int DEF_LINE_COUNT  = 4;
  localparam int DEF_LINE_LENGTH = 20;

  // Fixed field widths
  localparam int LINE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int OFFSET_W   = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Character and command byte codes
  localparam logic [CHAR_W-1:0] NUL_CODE     = 8'h00;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] DDRAM_BASE   = 8'h80;

  // Register reset values
  localparam logic [CHAR_W-1:0]   RST_FUNCTION_SET = 8'd56;
  localparam logic [CHAR_W-1:0]   RST_DISPLAY_ON   = 8'd12;
  localparam logic [CHAR_W-1:0]   RST_ENTRY_MODE   = 8'd6;
  localparam logic [CHAR_W-1:0]   RST_CLEAR        = 8'd1;
  localparam logic [OFFSET_W-1:0] RST_LINE0_OFFSET = 7'd0;
  localparam logic [OFFSET_W-1:0] RST_LINE1_OFFSET = 7'd64;
  localparam logic [OFFSET_W-1:0] RST_LINE2_OFFSET = 7'd20;
  localparam logic [OFFSET_W-1:0] RST_LINE3_OFFSET = 7'd84;

  // Host item opcodes
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SETPOS = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Next tick period select
  typedef enum logic [1:0] {
    DELAY_KEEP  = 2'd0,
    DELAY_SHORT = 2'd1,
    DELAY_LONG  = 2'd2
  } delay_t;

  // Input item
  typedef struct packed {
    cmd_t        command;
    logic [7:0]  char_code;
    logic [2:0]  target_line;
    logic [4:0]  target_col;
  } in_t;

  // Result item
  typedef struct packed {
    logic        bus_strobe;
    logic        bus_rs;
    logic [7:0]  bus_byte;
    delay_t      delay_select;
  } out_t;

  // Configuration register contents
  typedef struct packed {
    logic [CHAR_W-1:0]              function_set_cmd;
    logic [CHAR_W-1:0]              display_on_cmd;
    logic [CHAR_W-1:0]              entry_mode_cmd;
    logic [CHAR_W-1:0]              clear_cmd;
    logic [3:0][OFFSET_W-1:0]       line_offset;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture item, read text store
    logic exec;   // apply item, load result register
    logic sweep;  // write one fill entry
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_clear;
    logic sweep_last;
  } dp_status_t;

endpackage

### design/char_lcd_refresh_controller.sv
// An item is captured into the item register, then executed into the result register;
// execute waits while the result is not taken, and no new item is accepted until then.
// A clear item adds a fill of all LINE_COUNT*LINE_LENGTH store entries (80 by default),
// one entry per cycle through the single text store write port, with in_ready low.
// Reset: the same fill pass writes zeros over the store (in_ready low);
// registers return to their defaults at once and stay writable during the pass.
module char_lcd_refresh_controller #(
  parameter int LINE_COUNT  = clcd_pkg::DEF_LINE_COUNT,
  parameter int LINE_LENGTH = clcd_pkg::DEF_LINE_LENGTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  clcd_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output clcd_pkg::out_t                   out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [clcd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  clcd_pkg::cfg_t       cfg;
  clcd_pkg::ctrl_cmd_t  cmd;
  clcd_pkg::dp_status_t status;

  // Configuration registers
  clcd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Transfer sequencing
  clcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Store, cursor and panel sequencer
  clcd_datapath #(
    .LINE_COUNT  (LINE_COUNT),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### design/clcd_regs.sv
// APB-style configuration register file for the character LCD controller.
module clcd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [clcd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output clcd_pkg::cfg_t                   cfg
);

  typedef enum logic [2:0] {
    REG_FUNCTION_SET = 3'd0,
    REG_DISPLAY_ON   = 3'd1,
    REG_ENTRY_MODE   = 3'd2,
    REG_CLEAR        = 3'd3,
    REG_LINE0        = 3'd4,
    REG_LINE1        = 3'd5,
    REG_LINE2        = 3'd6,
    REG_LINE3        = 3'd7
  } reg_idx_t;

  clcd_pkg::cfg_t cfg_r;
  reg_idx_t       reg_idx;
  logic           wr_en;

  assign reg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.function_set_cmd <= clcd_pkg::RST_FUNCTION_SET;
      cfg_r.display_on_cmd   <= clcd_pkg::RST_DISPLAY_ON;
      cfg_r.entry_mode_cmd   <= clcd_pkg::RST_ENTRY_MODE;
      cfg_r.clear_cmd        <= clcd_pkg::RST_CLEAR;
      cfg_r.line_offset[0]   <= clcd_pkg::RST_LINE0_OFFSET;
      cfg_r.line_offset[1]   <= clcd_pkg::RST_LINE1_OFFSET;
      cfg_r.line_offset[2]   <= clcd_pkg::RST_LINE2_OFFSET;
      cfg_r.line_offset[3]   <= clcd_pkg::RST_LINE3_OFFSET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FUNCTION_SET: cfg_r.function_set_cmd <= cfg_pwdata[clcd_pkg::CHAR_W-1:0];
        REG_DISPLAY_ON:   cfg_r.display_on_cmd   <= cfg_pwdata[clcd_pkg::CHAR_W-1:0];
        REG_ENTRY_MODE:   cfg_r.entry_mode_cmd   <= cfg_pwdata[clcd_pkg::CHAR_W-1:0];
        REG_CLEAR:        cfg_r.clear_cmd        <= cfg_pwdata[clcd_pkg::CHAR_W-1:0];
        REG_LINE0:        cfg_r.line_offset[0]   <= cfg_pwdata[clcd_pkg::OFFSET_W-1:0];
        REG_LINE1:        cfg_r.line_offset[1]   <= cfg_pwdata[clcd_pkg::OFFSET_W-1:0];
        REG_LINE2:        cfg_r.line_offset[2]   <= cfg_pwdata[clcd_pkg::OFFSET_W-1:0];
        REG_LINE3:        cfg_r.line_offset[3]   <= cfg_pwdata[clcd_pkg::OFFSET_W-1:0];
        default:          cfg_r.clear_cmd        <= cfg_r.clear_cmd;
      endcase
    end
  end

  // Readback mux
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_FUNCTION_SET: cfg_prdata = clcd_pkg::CFG_DATA_W'(cfg_r.function_set_cmd);
      REG_DISPLAY_ON:   cfg_prdata = clcd_pkg::CFG_DATA_W'(cfg_r.display_on_cmd);
      REG_ENTRY_MODE:   cfg_prdata = clcd_pkg::CFG_DATA_W'(cfg_r.entry_mode_cmd);
      REG_CLEAR:        cfg_prdata = clcd_pkg::CFG_DATA_W'(cfg_r.clear_cmd);
      REG_LINE0:        cfg_prdata = clcd_pkg::CFG_DATA_W'(cfg_r.line_offset[0]);
      REG_LINE1:        cfg_prdata = clcd_pkg::CFG_DATA_W'(cfg_r.line_offset[1]);
      REG_LINE2:        cfg_prdata = clcd_pkg::CFG_DATA_W'(cfg_r.line_offset[2]);
      REG_LINE3:        cfg_prdata = clcd_pkg::CFG_DATA_W'(cfg_r.line_offset[3]);
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

### design/clcd_ctrl.sv
// Handshake and sequencing controller for the character LCD controller.
module clcd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  clcd_pkg::dp_status_t  status,
  output clcd_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result register is free when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.exec  = (state_r == S_EXEC) && out_free;
  assign cmd.sweep = (state_r == S_SWEEP);

  // Next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_SWEEP: begin
        if (status.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = status.is_clear ? S_SWEEP : S_IDLE;
        end
      end
      default: state_nxt = S_SWEEP;
    endcase
  end

  // State and registered outputs; reset starts the zero fill of the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/clcd_datapath.sv
// Text store, cursor, panel sequencer registers and result register.
module clcd_datapath #(
  parameter int LINE_COUNT  = clcd_pkg::DEF_LINE_COUNT,
  parameter int LINE_LENGTH = clcd_pkg::DEF_LINE_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clcd_pkg::ctrl_cmd_t   cmd,
  output clcd_pkg::dp_status_t  status,
  input  clcd_pkg::cfg_t        cfg,
  input  clcd_pkg::in_t         in_data,
  output clcd_pkg::out_t        out_data
);

  localparam int STORE_SIZE = LINE_COUNT * LINE_LENGTH;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int RAW_W      = ADDR_W + 1;
  localparam int IDX_W      = $clog2(LINE_LENGTH + 1);
  localparam int LCNT_W     = clcd_pkg::LINE_W + 1;
  localparam int CW         = clcd_pkg::CHAR_W;

  // Panel command sequencer codes
  typedef enum logic [2:0] {
    PS_INIT    = 3'd0,
    PS_ENABLE  = 3'd1,
    PS_ENTRY   = 3'd2,
    PS_CLEAR   = 3'd3,
    PS_IDLE    = 3'd4,
    PS_ADDRESS = 3'd5,
    PS_CHARS   = 3'd6
  } panel_st_t;

  logic [CW-1:0] text_mem [STORE_SIZE];

  clcd_pkg::in_t  item_r;
  clcd_pkg::out_t out_r, out_nxt;
  logic [CW-1:0]  rd_data_r;

  panel_st_t                    panel_st_r, panel_st_nxt;
  logic                         pending_r, pending_nxt;
  logic [clcd_pkg::LINE_W-1:0]  rline_r, rline_nxt;
  logic [IDX_W-1:0]             ridx_r, ridx_nxt;
  logic                         end_seen_r, end_seen_nxt;
  logic [clcd_pkg::LINE_W-1:0]  cur_line_r, cur_line_nxt;
  logic [IDX_W-1:0]             cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0]            sweep_addr_r;
  logic [CW-1:0]                fill_r;

  logic [RAW_W-1:0]             rd_raw, wr_raw;
  logic                         rd_in_range;
  logic                         ex_we;
  logic [CW-1:0]                ex_wdata;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [CW-1:0]                mem_wdata;
  logic [CW-1:0]                ch;
  logic [LCNT_W-1:0]            next_line;
  logic [clcd_pkg::LINE_W-1:0]  next_rline;
  logic                         rline_ok;
  logic                         col_ok;

  assign out_data = out_r;

  // Store addresses of the refresh position and of the cursor
  assign rd_raw = RAW_W'(rline_r) * RAW_W'(LINE_LENGTH) + RAW_W'(ridx_r);
  assign wr_raw = RAW_W'(cur_line_r) * RAW_W'(LINE_LENGTH) + RAW_W'(cur_col_r);
  assign rd_in_range = (rd_raw < RAW_W'(STORE_SIZE));

  assign rline_ok   = ({1'b0, rline_r} < LCNT_W'(LINE_COUNT));
  assign col_ok     = (cur_col_r < IDX_W'(LINE_LENGTH)) &&
                      ({1'b0, cur_line_r} < LCNT_W'(LINE_COUNT));
  assign next_line  = LCNT_W'({1'b0, cur_line_r} + 1'b1);
  assign next_rline = clcd_pkg::LINE_W'(rline_r + 1'b1);

  assign status.is_clear   = (item_r.command == clcd_pkg::CMD_CLEAR);
  assign status.sweep_last = (sweep_addr_r == ADDR_W'(STORE_SIZE - 1));

  // Item execution
  always_comb begin
    panel_st_nxt = panel_st_r;
    pending_nxt  = pending_r;
    rline_nxt    = rline_r;
    ridx_nxt     = ridx_r;
    end_seen_nxt = end_seen_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    out_nxt      = '0;
    ex_we        = 1'b0;
    ex_wdata     = item_r.char_code;
    ch           = rd_data_r;
    case (item_r.command)
      clcd_pkg::CMD_TICK: begin
        unique case (panel_st_r)
          PS_INIT: begin
            out_nxt = '{1'b1, 1'b0, cfg.function_set_cmd, clcd_pkg::DELAY_LONG};
            panel_st_nxt = PS_ENABLE;
          end
          PS_ENABLE: begin
            out_nxt = '{1'b1, 1'b0, cfg.display_on_cmd, clcd_pkg::DELAY_SHORT};
            panel_st_nxt = PS_ENTRY;
          end
          PS_ENTRY: begin
            out_nxt = '{1'b1, 1'b0, cfg.entry_mode_cmd, clcd_pkg::DELAY_SHORT};
            panel_st_nxt = PS_CLEAR;
          end
          PS_CLEAR: begin
            out_nxt = '{1'b1, 1'b0, cfg.clear_cmd, clcd_pkg::DELAY_LONG};
            panel_st_nxt = PS_IDLE;
          end
          PS_IDLE: begin
            if (pending_r) begin
              out_nxt.delay_select = clcd_pkg::DELAY_SHORT;
              panel_st_nxt = PS_ADDRESS;
              rline_nxt    = '0;
              pending_nxt  = 1'b0;
            end
          end
          PS_ADDRESS: begin
            out_nxt.delay_select = clcd_pkg::DELAY_SHORT;
            if (rline_ok) begin
              out_nxt.bus_strobe = 1'b1;
              out_nxt.bus_byte   = clcd_pkg::DDRAM_BASE |
                                   {1'b0, cfg.line_offset[rline_r]};
            end
            panel_st_nxt = PS_CHARS;
          end
          PS_CHARS: begin
            if (ridx_r < IDX_W'(LINE_LENGTH) && rline_ok) begin
              // Terminator and everything after it go out as spaces
              if (end_seen_r || rd_data_r == clcd_pkg::NUL_CODE) begin
                end_seen_nxt = 1'b1;
                ch           = clcd_pkg::SPACE_CODE;
              end
              ridx_nxt = IDX_W'(ridx_r + 1'b1);
              out_nxt  = '{1'b1, 1'b1, ch, clcd_pkg::DELAY_SHORT};
            end else begin
              ridx_nxt     = '0;
              end_seen_nxt = 1'b0;
              out_nxt.delay_select = clcd_pkg::DELAY_LONG;
              if ({1'b0, next_rline} >= LCNT_W'(LINE_COUNT) || next_rline == '0) begin
                rline_nxt    = '0;
                panel_st_nxt = PS_IDLE;
              end else begin
                rline_nxt    = next_rline;
                panel_st_nxt = PS_ADDRESS;
              end
            end
          end
          default: begin
            panel_st_nxt = PS_INIT;
          end
        endcase
      end
      clcd_pkg::CMD_WRITE: begin
        if (item_r.char_code != clcd_pkg::NUL_CODE) begin
          ex_we = col_ok;
          if (item_r.char_code == clcd_pkg::NEWLINE_CODE) begin
            ex_wdata = clcd_pkg::NUL_CODE;
            cur_line_nxt = (next_line >= LCNT_W'(LINE_COUNT)) ?
                           '0 : next_line[clcd_pkg::LINE_W-1:0];
            cur_col_nxt  = '0;
          end else if (cur_col_r < IDX_W'(LINE_LENGTH)) begin
            cur_col_nxt = IDX_W'(cur_col_r + 1'b1);
          end
          pending_nxt = 1'b1;
        end
      end
      clcd_pkg::CMD_SETPOS: begin
        if (item_r.target_line < LCNT_W'(LINE_COUNT) &&
            item_r.target_col < 5'(LINE_LENGTH)) begin
          cur_line_nxt = item_r.target_line[clcd_pkg::LINE_W-1:0];
          cur_col_nxt  = IDX_W'(item_r.target_col);
        end
      end
      default: begin
        // Clear: the store fill runs as a sweep afterwards
        cur_line_nxt = '0;
        cur_col_nxt  = '0;
        ridx_nxt     = '0;
        end_seen_nxt = 1'b0;
        panel_st_nxt = PS_CLEAR;
      end
    endcase
  end

  // Store write port: fill sweep or character write
  always_comb begin
    if (cmd.sweep) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr_r;
      mem_wdata = fill_r;
    end else begin
      mem_we    = cmd.exec && ex_we;
      mem_waddr = wr_raw[ADDR_W-1:0];
      mem_wdata = ex_wdata;
    end
  end

  // Text store and its registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.load && rd_in_range) begin
      rd_data_r <= text_mem[rd_raw[ADDR_W-1:0]];
    end
  end

  // Item and result payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  // Sequencer, cursor and fill control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_st_r   <= PS_INIT;
      pending_r    <= 1'b1;
      rline_r      <= '0;
      ridx_r       <= '0;
      end_seen_r   <= 1'b0;
      cur_line_r   <= '0;
      cur_col_r    <= '0;
      sweep_addr_r <= '0;
      fill_r       <= clcd_pkg::NUL_CODE;
    end else begin
      if (cmd.exec) begin
        panel_st_r <= panel_st_nxt;
        pending_r  <= pending_nxt;
        rline_r    <= rline_nxt;
        ridx_r     <= ridx_nxt;
        end_seen_r <= end_seen_nxt;
        cur_line_r <= cur_line_nxt;
        cur_col_r  <= cur_col_nxt;
        if (status.is_clear) begin
          fill_r       <= clcd_pkg::SPACE_CODE;
          sweep_addr_r <= '0;
        end
      end else if (cmd.sweep) begin
        sweep_addr_r <= status.sweep_last ? '0 : ADDR_W'(sweep_addr_r + 1'b1);
      end
    end
  end

endmodule
